>>> rtl/wlq_pkg.sv
// Shared types, widths and helpers for the wide line setup pipeline.
`timescale 1ns / 1ps

package wlq_pkg;

	localparam int CB     = 15;          // coordinate bits
	localparam int ROOT_W = CB + 1;      // integer root of dx^2 + dy^2
	localparam int SQ_W   = 2 * ROOT_W;  // radicand
	localparam int REM_W  = ROOT_W + 3;  // root remainder
	localparam int M_W    = 9;           // m = 2(w-1)
	localparam int Q_W    = 9;           // quotient, never above m
	localparam int NUM_W  = M_W + CB;    // m * |d|
	localparam int A_W    = Q_W + 2;     // signed offset in quarter units
	localparam int IN_W   = ((4 * CB + 8 + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_VEC    = 2'd0,
		KIND_RECT   = 2'd1,
		KIND_QUAD   = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                        kind;
		logic [CB-1:0]                x0;
		logic [CB-1:0]                y0;
		logic [CB-1:0]                x1;
		logic [CB-1:0]                y1;
		logic                         neg;
		logic [3:0][15:0]             pc;
		logic [CB-1:0]                adx;
		logic [CB-1:0]                ady;
		logic [M_W-1:0]               m;
		logic [1:0][2*CB-1:0]         sq;
		logic [1:0][NUM_W-1:0]        num;
		logic [SQ_W-1:0]              rad;
		logic [REM_W-1:0]             rem;
		logic [ROOT_W-1:0]            root;
		logic [1:0][Q_W-1:0]          dlo;
		logic [1:0][ROOT_W-1:0]       drem;
		logic [1:0][Q_W-1:0]          dq;
	} item_t;

	typedef struct packed {
		logic signed [A_W-1:0] main_part;
		logic signed [A_W-1:0] other_part;
	} split_t;

	function automatic logic [31:0] sx32(input logic [CB-1:0] v);
		logic signed [CB-1:0] t;
		t = v;
		return 32'(t);
	endfunction

	// Quarter-unit split: raise on remainder 3, second part one more on remainder 2.
	function automatic split_t split_quarter(input logic signed [A_W-1:0] v);
		split_t s;
		logic signed [A_W-1:0] q;
		q = v >>> 2;
		s.main_part  = q + ((v[1:0] == 2'd3) ? A_W'(1) : A_W'(0));
		s.other_part = s.main_part + ((v[1:0] == 2'd2) ? A_W'(1) : A_W'(0));
		return s;
	endfunction

endpackage

>>> rtl/wlq_sqrt_cell.sv
// One digit of the integer square root: takes two radicand bits, yields one root bit.
`timescale 1ns / 1ps

module wlq_sqrt_cell
	import wlq_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  item_t d,
	output item_t q
);

	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] trial;
	item_t            nxt;

	always_comb begin
		r2       = {d.rem[REM_W-3:0], d.rad[SQ_W-1:SQ_W-2]};
		trial    = REM_W'({d.root, 2'b01});
		nxt      = d;
		nxt.rad  = {d.rad[SQ_W-3:0], 2'b00};
		if (r2 >= trial) begin
			nxt.rem  = r2 - trial;
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = r2;
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> rtl/wlq_div_cell.sv
// One restoring divide step for both offset lanes, one quotient bit each.
`timescale 1ns / 1ps

module wlq_div_cell
	import wlq_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  item_t d,
	output item_t q
);

	logic [1:0][ROOT_W:0]   r;
	logic [1:0]             ge;
	logic [ROOT_W:0]        dv;
	item_t                  nxt;

	always_comb begin
		dv  = (ROOT_W + 1)'(d.root);
		nxt = d;
		for (int k = 0; k < 2; k++) begin
			r[k]  = {d.drem[k], d.dlo[k][Q_W-1]};
			ge[k] = (r[k] >= dv);
			nxt.dlo[k]  = {d.dlo[k][Q_W-2:0], 1'b0};
			nxt.drem[k] = ge[k] ? ROOT_W'(r[k] - dv) : ROOT_W'(r[k]);
			nxt.dq[k]   = {d.dq[k][Q_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> rtl/wide_line_to_quad_setup_unit.sv
// Top level: line command in, drawing primitive out, through a row of root and divide cells.
`timescale 1ns / 1ps

// Accepts one line command every cycle unless the output stalls, and passes it through
// three setup stages (ordering, squares and products, sum), a row of 16 square
// root cells that each settle one bit of the line length, a row of 9 divide cells
// that each settle one bit of both corner offsets, and the output register. The
// whole row advances together; while a result waits at the output, the row holds
// and s_axis_tready is low, and it rises again as soon as that item is taken.

module wide_line_to_quad_setup_unit
	import wlq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// start_x, start_y, end_x, end_y, line_width, zero pad
	input  logic [IN_W-1:0] s_axis_tdata,
	// textured
	input  logic            s_axis_tuser,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
	output logic [127:0]    m_axis_tdata,
	// prim_kind
	output logic [1:0]      m_axis_tuser
);

	localparam int NST = 3 + ROOT_W + Q_W;

	logic           en;
	logic [NST-1:0] pipe_v_q;
	logic           out_v_q;
	logic [127:0]   out_data_q;
	kind_t          out_kind_q;

	item_t st_s1, st_s2, st_s3;
	item_t s1_d, s2_d, s3_d;
	item_t sq_chain  [ROOT_W+1];
	item_t div_chain [Q_W+1];

	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_q <= '0;
			out_v_q  <= 1'b0;
		end else if (en) begin
			pipe_v_q <= {pipe_v_q[NST-2:0], s_axis_tvalid};
			out_v_q  <= pipe_v_q[NST-1];
		end
	end

	// Setup: classify, order left to right, preset vector and rectangle corners.
	logic [CB-1:0] sx, sy, ex, ey, ox0, oy0, ox1, oy1;
	logic [7:0]    w;
	logic          swap;
	kind_t         kind;
	logic [CB:0]   ddy;
	logic [3:0][15:0] pc;

	always_comb begin
		sx   = s_axis_tdata[CB-1:0];
		sy   = s_axis_tdata[2*CB-1:CB];
		ex   = s_axis_tdata[3*CB-1:2*CB];
		ey   = s_axis_tdata[4*CB-1:3*CB];
		w    = s_axis_tdata[4*CB+7:4*CB];
		swap = $signed(sx) > $signed(ex);
		ox0  = swap ? ex : sx;
		oy0  = swap ? ey : sy;
		ox1  = swap ? sx : ex;
		oy1  = swap ? sy : ey;
		// dy spans one bit more than a coordinate
		ddy  = {oy1[CB-1], oy1} - {oy0[CB-1], oy0};
		pc   = '0;
		priority if (s_axis_tuser || w == 8'd2) begin
			kind = KIND_REJECT;
		end else if (w <= 8'd1) begin
			kind  = KIND_VEC;
			pc[0] = 16'(sx32(sx));
			pc[1] = 16'(sx32(sy));
			pc[2] = 16'(sx32(ex));
			pc[3] = 16'(sx32(ey));
		end else if (sx == ex) begin
			kind  = KIND_RECT;
			pc[0] = 16'(sx32(sx) - 32'(w >> 1));
			pc[1] = 16'(sx32(sy));
			pc[2] = 16'(sx32(sx) + 32'((w - 8'd1) >> 1));
			pc[3] = 16'(sx32(ey));
		end else if (oy0 == oy1) begin
			kind  = KIND_RECT;
			pc[0] = 16'(sx32(ox0));
			pc[1] = 16'(sx32(oy0) - 32'(w >> 1));
			pc[2] = 16'(sx32(ox1));
			pc[3] = 16'(sx32(oy0) + 32'((w - 8'd1) >> 1));
		end else begin
			kind = KIND_QUAD;
		end
	end

	always_comb begin
		s1_d      = '0;
		s1_d.kind = kind;
		s1_d.x0   = ox0;
		s1_d.y0   = oy0;
		s1_d.x1   = ox1;
		s1_d.y1   = oy1;
		s1_d.pc   = pc;
		s1_d.neg  = ddy[CB];
		s1_d.adx  = ox1 - ox0;
		s1_d.ady  = ddy[CB] ? CB'(-ddy) : CB'(ddy);
		s1_d.m    = {w - 8'd1, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= s1_d;
		end
	end

	always_comb begin
		s2_d        = st_s1;
		s2_d.sq[0]  = (2*CB)'(st_s1.adx) * (2*CB)'(st_s1.adx);
		s2_d.sq[1]  = (2*CB)'(st_s1.ady) * (2*CB)'(st_s1.ady);
		s2_d.num[0] = NUM_W'(st_s1.m) * NUM_W'(st_s1.ady);
		s2_d.num[1] = NUM_W'(st_s1.m) * NUM_W'(st_s1.adx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= s2_d;
		end
	end

	always_comb begin
		s3_d      = st_s2;
		s3_d.rad  = SQ_W'(st_s2.sq[0]) + SQ_W'(st_s2.sq[1]);
		s3_d.rem  = '0;
		s3_d.root = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3 <= s3_d;
		end
	end

	assign sq_chain[0] = st_s3;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		wlq_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_chain[g]),
			.q   (sq_chain[g+1])
		);
	end

	// Quotient fits in Q_W bits, so the high dividend bits seed the remainder.
	always_comb begin
		div_chain[0] = sq_chain[ROOT_W];
		for (int k = 0; k < 2; k++) begin
			div_chain[0].drem[k] = ROOT_W'(sq_chain[ROOT_W].num[k][NUM_W-1:Q_W]);
			div_chain[0].dlo[k]  = sq_chain[ROOT_W].num[k][Q_W-1:0];
			div_chain[0].dq[k]   = '0;
		end
	end

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		wlq_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (div_chain[g]),
			.q   (div_chain[g+1])
		);
	end

	// Finish: signed offsets, quarter split, quadrilateral corners, or the preset corners for other kinds.
	item_t                 fin;
	logic signed [A_W-1:0] va, vb;
	split_t                sa, sb;
	logic [31:0]           fx0, fy0, fx1, fy1, xr, xl, yu, yd;
	logic [127:0]          res;

	always_comb begin
		fin = div_chain[Q_W];
		va  = fin.neg ? -$signed(A_W'(fin.dq[0])) : $signed(A_W'(fin.dq[0]));
		vb  = $signed(A_W'(fin.dq[1]));
		sa  = split_quarter(va);
		sb  = split_quarter(vb);
		xr  = 32'(sa.main_part);
		xl  = 32'(sa.other_part);
		yu  = 32'(sb.main_part);
		yd  = 32'(sb.other_part);
		fx0 = sx32(fin.x0);
		fy0 = sx32(fin.y0);
		fx1 = sx32(fin.x1);
		fy1 = sx32(fin.y1);
		if (fin.kind == KIND_QUAD) begin
			res = {16'(fy1 - yu), 16'(fx1 + xr), 16'(fy1 + yd), 16'(fx1 - xl),
			       16'(fy0 + yd), 16'(fx0 - xl), 16'(fy0 - yu), 16'(fx0 + xr)};
		end else begin
			res = {64'd0, fin.pc};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
			out_kind_q <= fin.kind;
		end
	end

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready does not follow output stall");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_REJECT |-> m_axis_tdata == '0)
		else $error("rejected primitive carries corners");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_VEC || m_axis_tuser == KIND_RECT)
		|-> m_axis_tdata[127:64] == '0)
		else $error("unused corners not zero");

	a_fill_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		en && pipe_v_q[NST-1] |=> m_axis_tvalid)
		else $error("item lost at output register");

endmodule

>>> tb/wide_line_to_quad_setup_unit_test.sv
// Testbench for the wide line setup unit: directed and random line commands against a predictor.
`timescale 1ns / 1ps

module wide_line_to_quad_setup_unit_test;
	import wlq_pkg::*;

	typedef struct {
		kind_t kind;
		logic [7:0][15:0] corner;
	} prim_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	prim_t prim_q[$];
	int mismatches;
	int cycles;
	int hold_cycles;
	bit gaps_on;
	bit failed;

	wide_line_to_quad_setup_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic longint isqrt(longint n);
		longint r, b;
		r = 0;
		for (int k = 20; k >= 0; k--) begin
			b = r | (longint'(1) << k);
			if (b * b <= n) r = b;
		end
		return r;
	endfunction

	function automatic void split(longint v, output longint mp, output longint op);
		longint q;
		q = v >>> 2;
		if ((v & 3) == 3) q++;
		mp = q;
		op = ((v & 3) == 2) ? q + 1 : q;
	endfunction

	function automatic prim_t predict_prim(logic signed [14:0] sx, logic signed [14:0] sy,
			logic signed [14:0] ex, logic signed [14:0] ey, logic [7:0] lw, logic tex);
		prim_t p;
		longint x0, y0, x1, y1, w, t, dx, dy, len, m, xr, xl, yu, yd;
		longint c[8];
		x0 = sx; y0 = sy; x1 = ex; y1 = ey; w = lw;
		foreach (c[i]) c[i] = 0;
		if (tex || w == 2) p.kind = KIND_REJECT;
		else if (w <= 1) begin
			p.kind = KIND_VEC;
			c[0] = x0; c[1] = y0; c[2] = x1; c[3] = y1;
		end else if (x0 == x1) begin
			p.kind = KIND_RECT;
			c[0] = x0 - (w >> 1); c[1] = y0; c[2] = x0 + ((w - 1) >> 1); c[3] = y1;
		end else begin
			if (x0 > x1) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			if (y0 == y1) begin
				p.kind = KIND_RECT;
				c[0] = x0; c[1] = y0 - (w >> 1); c[2] = x1; c[3] = y0 + ((w - 1) >> 1);
			end else begin
				dx = x1 - x0; dy = y1 - y0;
				len = isqrt(dx * dx + dy * dy);
				if (len < 1) len = 1;
				m = 2 * (w - 1);
				split((m * dy) / len, xr, xl);
				split((m * dx) / len, yu, yd);
				p.kind = KIND_QUAD;
				c[0] = x0 + xr; c[1] = y0 - yu; c[2] = x0 - xl; c[3] = y0 + yd;
				c[4] = x1 - xl; c[5] = y1 + yd; c[6] = x1 + xr; c[7] = y1 - yu;
			end
		end
		foreach (c[i]) p.corner[i] = c[i][15:0];
		return p;
	endfunction

	// Keep valid high between items that follow without a gap.
	task automatic send_line(logic [14:0] sx, logic [14:0] sy, logic [14:0] ex,
			logic [14:0] ey, logic [7:0] lw, logic tex);
		int gap;
		gap = gaps_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= IN_W'({lw, ey, ex, sy, sx});
		s_axis_tuser <= tex;
		s_axis_tvalid <= 1'b1;
		prim_q.push_back(predict_prim(sx, sy, ex, ey, lw, tex));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when requested.
	initial begin
		int wait_n;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			wait_n = gaps_on ? $urandom_range(0, 18) : 0;
			if (wait_n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		prim_t e;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (prim_q.size() == 0) begin
					failed = 1'b1;
					$display("unexpected primitive kind %0d", m_axis_tuser);
				end else begin
					e = prim_q.pop_front();
					if (m_axis_tuser != e.kind || m_axis_tdata != e.corner) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp kind %0d corners %h, got kind %0d corners %h",
								e.kind, e.corner, m_axis_tuser, m_axis_tdata);
					end
				end
			end
		end
	end

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (prim_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed;
		send_line(15'h4000, 15'h4000, 15'h3fff, 15'h3fff, 8'd255, 1'b0);
		send_line(15'h3fff, 15'h3fff, 15'h4000, 15'h4000, 8'd3, 1'b0);
		send_line(15'd10, 15'd20, 15'd10, 15'd20, 8'd5, 1'b0);
		send_line(15'd10, 15'd20, 15'd10, 15'd90, 8'd4, 1'b0);
		send_line(15'd90, 15'd20, 15'd10, 15'd20, 8'd7, 1'b0);
		send_line(15'd1, 15'd2, 15'd3, 15'd4, 8'd2, 1'b1);
		send_line(15'd1, 15'd2, 15'd3, 15'd4, 8'd2, 1'b0);
		send_line(15'd1, 15'd2, 15'd3, 15'd4, 8'd9, 1'b1);
		send_line(15'd1, 15'd2, 15'd3, 15'd4, 8'd0, 1'b0);
		send_line(15'h7fff, 15'h0000, 15'h3fff, 15'h7fff, 8'd1, 1'b0);
		send_line(15'd0, 15'd0, 15'd1, 15'd1, 8'd3, 1'b0);
		send_line(15'd50, 15'd0, 15'd0, 15'd7, 8'd200, 1'b0);
		send_line(15'd0, 15'd0, 15'd1, 15'h4000, 8'd255, 1'b0);
		send_line(15'h4000, 15'd0, 15'h3fff, 15'd1, 8'd128, 1'b0);
		drain;
	endtask

	function automatic logic [14:0] rand_coord;
		case ($urandom_range(0, 3))
			0: return 15'($urandom);
			1: return 15'($urandom_range(0, 40)) - 15'd20;
			2: return $urandom_range(0, 1) ? 15'h4000 : 15'h3fff;
			default: return 15'($urandom_range(0, 2000)) - 15'd1000;
		endcase
	endfunction

	task automatic test_random(int n);
		logic [14:0] sx, sy, ex, ey;
		repeat (n) begin
			sx = rand_coord(); sy = rand_coord(); ex = rand_coord(); ey = rand_coord();
			case ($urandom_range(0, 9))
				0: ex = sx;
				1: ey = sy;
				default: ;
			endcase
			send_line(sx, sy, ex, ey, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
				: 8'($urandom), $urandom_range(0, 9) == 0);
		end
	endtask

	// Offer items without gaps while the receiver holds off, so the row fills and stalls.
	task automatic test_backpressure;
		gaps_on = 1'b0;
		hold_cycles = 200;
		test_random(60);
		drain;
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		mismatches = 0;
		hold_cycles = 0;
		failed = 1'b0;
		gaps_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed;
		test_random(500);
		drain;
		test_backpressure;
		gaps_on = 1'b0;
		test_random(300);
		gaps_on = 1'b1;
		test_random(380);
		drain;
		repeat (60) @(posedge clk);
		if (!failed && mismatches == 0 && prim_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/wlq_pkg.sv
rtl/wlq_sqrt_cell.sv
rtl/wlq_div_cell.sv
rtl/wide_line_to_quad_setup_unit.sv
tb/wide_line_to_quad_setup_unit_test.sv
